// ===== rtl/core/bellman_ford_shortest_paths_core_assert.svh =====
// assertion macros shared by the shortest path core
`ifndef BELLMAN_FORD_SHORTEST_PATHS_CORE_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_CORE_ASSERT_SVH

// same-cycle implication
`define BFSP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfsp check failed");

// next-cycle implication
`define BFSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfsp check failed");

`endif

// ===== rtl/core/bfsp_pkg.sv =====
// shared types and constants of the shortest path core
package bfsp_pkg;

   localparam int NODE_W     = 6;
   localparam int NCFG_W     = 7;
   localparam int ACT_W      = 2;
   localparam int COST_IN_W  = 16;
   localparam int DIST_W     = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RUN   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE     = 1'd1;

   localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_ffff;
   localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_READ,
      ST_RELAX,
      ST_EMIT_RD,
      ST_EMIT_PUT,
      ST_NEG
   } state_type;

   typedef struct packed {
      logic              ren;
      logic [NODE_W-1:0] raddr_a;
      logic [NODE_W-1:0] raddr_b;
      logic              wen;
      logic [NODE_W-1:0] waddr;
      logic              wmark;
      logic [DIST_W-1:0] wdist;
   } dist_req_type;

   typedef struct packed {
      logic              mark_a;
      logic [DIST_W-1:0] dist_a;
      logic              mark_b;
      logic [DIST_W-1:0] dist_b;
   } dist_rsp_type;

endpackage

// ===== rtl/core/bellman_ford_shortest_paths_core.sv =====
// bellman-ford shortest path core: edge list store, relaxation sequencer, result stage
// an add or clear beat is handled in idle; a run initialises all n nodes, then makes up to n
// passes over the stored edges (per usable edge, a read of the distance memory, then a relax and write),
// then a read and a put per node result, or one negative cycle result
// a pass with no relaxation ends the run early; reset clears control, memories hold garbage
`include "bellman_ford_shortest_paths_core_assert.svh"
module bellman_ford_shortest_paths_core import bfsp_pkg::*; #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 1024,
   parameter int COST_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ACT_W-1:0]             req_action,
   input  logic [NODE_W-1:0]            req_edge_from,
   input  logic [NODE_W-1:0]            req_edge_to,
   input  logic signed [COST_IN_W-1:0]  req_edge_cost,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [NODE_W-1:0]            rsp_node_index,
   output logic signed [DIST_W-1:0]     rsp_distance,
   output logic                         rsp_reachable,
   output logic                         rsp_negative_cycle,
   output logic                         rsp_edges_dropped,
   output logic                         rsp_last,
   input  logic                         csr_wen,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EC_W = $clog2(MAX_EDGES + 1);
   localparam int NI_W = $clog2(MAX_NODES);
   localparam int EW_W = 2 * NODE_W + COST_BITS;
   localparam logic [NCFG_W-1:0] NODES_LIM = NCFG_W'(MAX_NODES);
   localparam logic [EC_W-1:0]   EDGES_LIM = EC_W'(MAX_EDGES);

   state_type state_ff, state_in;

   logic [NCFG_W-1:0] node_count_ff;
   logic [NODE_W-1:0] source_ff;
   logic [NCFG_W-1:0] n_ff, n_in;
   logic [EC_W-1:0]   edge_count_ff, edge_count_in;
   logic              ovf_ff, ovf_in;
   logic [EC_W-1:0]   edge_idx_ff, edge_idx_in;
   logic [NCFG_W-1:0] pass_ff, pass_in;
   logic [NCFG_W-1:0] node_ff, node_in;
   logic              any_ff, any_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]        rsp_node_ff, rsp_node_in;
   logic signed [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic                     rsp_reach_ff, rsp_reach_in;
   logic                     rsp_neg_ff, rsp_neg_in;
   logic                     rsp_drop_ff, rsp_drop_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic              req_fire;
   logic [NCFG_W-1:0] n_eff;
   logic              out_free;

   logic              edge_wen;
   logic [EW_W-1:0]   edge_wdata;
   logic [EW_W-1:0]   edge_rdata;
   logic [DIST_W-1:0] cost_wide;

   logic [NODE_W-1:0]           e_from;
   logic [NODE_W-1:0]           e_to;
   logic signed [COST_BITS-1:0] e_cost;
   logic                        usable;
   logic                        edge_last;
   logic                        pass_last;
   logic                        node_last;

   logic signed [DIST_W:0]   sum;
   logic signed [DIST_W-1:0] cand;
   logic signed [DIST_W-1:0] dist_u;
   logic signed [DIST_W-1:0] dist_v;
   logic                     relax;
   logic                     any_now;

   dist_req_type dist_req;
   dist_rsp_type dist_rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NCFG_W'(1);
         source_ff     <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_NODE_COUNT: node_count_ff <= csr_wdata[NCFG_W-1:0];
            CSR_SOURCE:     source_ff     <= csr_wdata[NODE_W-1:0];
            default:        ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign n_eff = (node_count_ff == '0)        ? NCFG_W'(1) :
                  (node_count_ff > NODES_LIM)  ? NODES_LIM  : node_count_ff;

   // edge word: tail, head, cost
   assign cost_wide  = DIST_W'(req_edge_cost);
   assign edge_wdata = {req_edge_from, req_edge_to, cost_wide[COST_BITS-1:0]};
   assign edge_wen   = req_fire && (req_action == ACT_ADD) && (edge_count_ff < EDGES_LIM);

   bfsp_edge_mem #(
      .DEPTH  (MAX_EDGES),
      .ADDR_W (EA_W),
      .WORD_W (EW_W)
   ) u_edge_mem (
      .clock (clock),
      .wen   (edge_wen),
      .waddr (edge_count_ff[EA_W-1:0]),
      .wdata (edge_wdata),
      .raddr (edge_idx_in[EA_W-1:0]),
      .rdata (edge_rdata)
   );

   bfsp_dist_mem #(
      .DEPTH  (MAX_NODES),
      .ADDR_W (NI_W)
   ) u_dist_mem (
      .clock (clock),
      .req   (dist_req),
      .rsp   (dist_rsp)
   );

   // read data always belongs to edge_idx_ff
   assign e_from = edge_rdata[EW_W-1 -: NODE_W];
   assign e_to   = edge_rdata[COST_BITS +: NODE_W];
   assign e_cost = edge_rdata[COST_BITS-1:0];
   assign usable = ({1'b0, e_from} < n_ff) && ({1'b0, e_to} < n_ff);

   assign edge_last = (edge_idx_ff + EC_W'(1)) == edge_count_ff;
   assign pass_last = (pass_ff + NCFG_W'(1)) == n_ff;
   assign node_last = (node_ff + NCFG_W'(1)) == n_ff;

   // saturating relax candidate
   assign dist_u = dist_rsp.dist_a;
   assign dist_v = dist_rsp.dist_b;
   assign sum    = (DIST_W + 1)'(dist_u) + (DIST_W + 1)'(e_cost);
   assign cand   = (sum[DIST_W] != sum[DIST_W-1]) ? (sum[DIST_W] ? DIST_MIN : DIST_MAX)
                                                  : sum[DIST_W-1:0];
   assign relax  = dist_rsp.mark_a && (!dist_rsp.mark_b || (cand < dist_v));
   assign any_now = any_ff || ((state_ff == ST_RELAX) && relax);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_action == ACT_RUN)) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            if (node_last) begin
               state_in = (edge_count_ff == '0) ? ST_EMIT_RD : ST_READ;
            end
         end
         ST_READ, ST_RELAX: begin
            if ((state_ff == ST_READ) && usable) begin
               state_in = ST_RELAX;
            end else if (edge_last) begin
               if (pass_last) begin
                  state_in = any_now ? ST_NEG : ST_EMIT_RD;
               end else begin
                  state_in = any_now ? ST_READ : ST_EMIT_RD;
               end
            end else begin
               state_in = ST_READ;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_PUT;
         end
         ST_EMIT_PUT: begin
            if (out_free) begin
               state_in = node_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_NEG: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and output controls
   always_comb begin
      n_in          = n_ff;
      edge_count_in = edge_count_ff;
      ovf_in        = ovf_ff;
      edge_idx_in   = edge_idx_ff;
      pass_in       = pass_ff;
      node_in       = node_ff;
      any_in        = any_ff;

      dist_req         = '0;
      dist_req.raddr_a = e_from;
      dist_req.raddr_b = e_to;
      dist_req.waddr   = e_to;
      dist_req.wmark   = 1'b1;
      dist_req.wdist   = cand;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_node_in  = rsp_node_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_reach_in = rsp_reach_ff;
      rsp_neg_in   = rsp_neg_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            edge_idx_in = '0;
            node_in     = '0;
            if (req_fire) begin
               case (req_action)
                  ACT_ADD: begin
                     if (edge_count_ff < EDGES_LIM) begin
                        edge_count_in = edge_count_ff + EC_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  ACT_RUN: begin
                     n_in = n_eff;
                  end
                  ACT_CLEAR: begin
                     edge_count_in = '0;
                     ovf_in        = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            dist_req.wen   = 1'b1;
            dist_req.waddr = node_ff[NODE_W-1:0];
            dist_req.wmark = (node_ff == {1'b0, source_ff});
            dist_req.wdist = '0;
            node_in        = node_last ? '0 : node_ff + NCFG_W'(1);
            edge_idx_in    = '0;
            pass_in        = '0;
            any_in         = 1'b0;
         end
         ST_READ, ST_RELAX: begin
            if ((state_ff == ST_READ) && usable) begin
               dist_req.ren = 1'b1;
            end else begin
               if (state_ff == ST_RELAX) begin
                  dist_req.wen = relax && !pass_last;
               end
               any_in = any_now;
               if (edge_last) begin
                  edge_idx_in = '0;
                  pass_in     = pass_ff + NCFG_W'(1);
                  any_in      = 1'b0;
               end else begin
                  edge_idx_in = edge_idx_ff + EC_W'(1);
               end
            end
         end
         ST_EMIT_RD: begin
            dist_req.ren     = 1'b1;
            dist_req.raddr_a = node_ff[NODE_W-1:0];
         end
         ST_EMIT_PUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = node_ff[NODE_W-1:0];
               rsp_dist_in  = dist_rsp.mark_a ? dist_u : '0;
               rsp_reach_in = dist_rsp.mark_a;
               rsp_neg_in   = 1'b0;
               rsp_drop_in  = ovf_ff;
               rsp_last_in  = node_last;
               node_in      = node_ff + NCFG_W'(1);
            end
         end
         ST_NEG: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = '0;
               rsp_dist_in  = '0;
               rsp_reach_in = 1'b0;
               rsp_neg_in   = 1'b1;
               rsp_drop_in  = ovf_ff;
               rsp_last_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         edge_count_ff <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         edge_idx_ff   <= '0;
         pass_ff       <= '0;
         node_ff       <= '0;
         any_ff        <= 1'b0;
         n_ff          <= NCFG_W'(1);
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
         edge_idx_ff   <= edge_idx_in;
         pass_ff       <= pass_in;
         node_ff       <= node_in;
         any_ff        <= any_in;
         n_ff          <= n_in;
      end
   end

   // result register, payload needs no reset
   always_ff @(posedge clock) begin
      rsp_node_ff  <= rsp_node_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_reach_ff <= rsp_reach_in;
      rsp_neg_ff   <= rsp_neg_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_node_index     = rsp_node_ff;
   assign rsp_distance       = rsp_dist_ff;
   assign rsp_reachable      = rsp_reach_ff;
   assign rsp_negative_cycle = rsp_neg_ff;
   assign rsp_edges_dropped  = rsp_drop_ff;
   assign rsp_last           = rsp_last_ff;

   `BFSP_ASSERT_IMP(a_cnt_cap, clock, reset, 1'b1, edge_count_ff <= EDGES_LIM)
   `BFSP_ASSERT_IMP(a_dist_wr, clock, reset, dist_req.wen, (state_ff == ST_INIT) || (state_ff == ST_RELAX))
   `BFSP_ASSERT_IMP(a_idx_rng, clock, reset, (state_ff == ST_READ) || (state_ff == ST_RELAX), edge_idx_ff < edge_count_ff)
   `BFSP_ASSERT_IMP(a_pass_rng, clock, reset, (state_ff == ST_READ) || (state_ff == ST_RELAX), pass_ff < n_ff)
   `BFSP_ASSERT_NEXT(a_emit_seq, clock, reset, state_ff == ST_EMIT_RD, state_ff == ST_EMIT_PUT)

endmodule

// ===== rtl/core/bfsp_edge_mem.sv =====
// edge list memory, one write and one registered read port
module bfsp_edge_mem import bfsp_pkg::*; #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int WORD_W = 28
) (
   input  logic              clock,
   input  logic              wen,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WORD_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WORD_W-1:0] rdata
);

   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/core/bfsp_dist_mem.sv =====
// per-node distance and reached mark memory, two read ports and one write port
module bfsp_dist_mem import bfsp_pkg::*; #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic         clock,
   input  dist_req_type req,
   output dist_rsp_type rsp
);

   logic [DIST_W:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (req.wen) begin
         mem[req.waddr[ADDR_W-1:0]] <= {req.wmark, req.wdist};
      end
      if (req.ren) begin
         {rsp.mark_a, rsp.dist_a} <= mem[req.raddr_a[ADDR_W-1:0]];
         {rsp.mark_b, rsp.dist_b} <= mem[req.raddr_b[ADDR_W-1:0]];
      end
   end

endmodule
